@@ rtl/klp_pkg.sv @@
// klp_pkg: shared constants, types and command codes of the keyframe player.
// Used by klp_serial_div and keyframe_lerp_player; no dependencies.
`default_nettype none

package klp_pkg;

  localparam int DW        = 32;              // channel width, signed Q16.16
  localparam int MAX_KEYS  = 16;              // keyframe table depth
  localparam int KEY_AW    = $clog2(MAX_KEYS);
  localparam int CNT_W     = KEY_AW + 1;      // key count holds MAX_KEYS itself
  localparam int STEP_BITS = 10;
  localparam int NUM_CH    = 3;               // x, z, turn
  localparam int CH_W      = 2;

  localparam logic [STEP_BITS-1:0] STEPS_RESET = STEP_BITS'(100);
  localparam logic [CNT_W-1:0]     MIN_KEYS    = CNT_W'(2);

  // Divider: exact key difference is one bit wider than a channel
  localparam int DIVIDEND_W = DW + 1;
  localparam int DIV_CW     = $clog2(DIVIDEND_W + 1);

  typedef logic [NUM_CH-1:0][DW-1:0] chan3_t;

  typedef enum logic [1:0] {
    CMD_STORE = 2'd0,
    CMD_PLAY  = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_A,
    ST_RD_B,
    ST_DIV_GO,
    ST_DIV_WAIT
  } state_e;

endpackage

`default_nettype wire

@@ rtl/keyframe_lerp_player.sv @@
// keyframe_lerp_player: top level, keyframe table, command sequencer, accumulators.
// Depends on klp_pkg and klp_serial_div.
`default_nettype none

// Linear keyframe player for three signed Q16.16 channels (x, z, turn).
// A command beat is taken when start is high and busy is low; every command
// gives exactly one result beat, shown on the result ports for one cycle with
// done_o high. The receiver cannot stall, so it must take each result beat in
// that cycle. Store, stop, a rejected play, no-op, a tick while stopped, a
// plain interpolation tick and a tick that ends playback finish without
// raising busy: the result appears in the cycle after the command and another
// command may follow every cycle. A play that starts playback, and a tick that
// moves on to the next segment, reload the segment: two reads of the keyframe
// table, then three increments (next key minus this key, divided by
// steps_per_segment) through one shared bit-serial divider at one quotient bit
// per cycle. Busy falls in the cycle that shows the result. The step count
// register is written through the cfg channel, which is always ready; write
// it only while the block is idle. A step count of zero divides by one and
// makes every tick advance a segment.
module keyframe_lerp_player
  import klp_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // command channel
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [1:0]           cmd_i,
  input  wire logic signed [DW-1:0] key_x_i,
  input  wire logic signed [DW-1:0] key_z_i,
  input  wire logic signed [DW-1:0] key_turn_i,
  // configuration: steps_per_segment
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [STEP_BITS-1:0] cfg_data_i,
  // result beat
  output logic                      done_o,
  output logic signed [DW-1:0]      pos_x_o,
  output logic signed [DW-1:0]      pos_z_o,
  output logic signed [DW-1:0]      heading_o,
  output logic                      playing_o,
  output logic [3:0]                segment_o,
  output logic                      ended_o,
  output logic                      rejected_o
);

  // Keyframe table: one 96-bit row per key {turn, z, x}, registered read
  chan3_t            mem_q [MAX_KEYS];
  chan3_t            rdata_q;
  logic [KEY_AW-1:0] rd_addr;
  logic              mem_we;
  chan3_t            mem_wdata;

  state_e                state_q, state_d;
  logic [CNT_W-1:0]      count_q, count_d;
  chan3_t                cur_q, cur_d;
  chan3_t                step_q, step_d;
  chan3_t                akey_q, akey_d;      // key where the segment starts
  logic                  run_q, run_d;
  logic [KEY_AW-1:0]     seg_q, seg_d;
  logic [STEP_BITS-1:0]  tick_q, tick_d;
  logic [STEP_BITS-1:0]  steps_q, steps_d;
  logic [CH_W-1:0]       ch_q, ch_d;
  logic                  load_cur_q, load_cur_d; // play start also loads key 0
  logic                  done_q, done_d;
  logic                  ended_q, ended_d;
  logic                  rej_q, rej_d;

  logic                  accept;
  cmd_e                  cmd;
  logic                  full;
  logic [CNT_W:0]        seg_end;
  logic                  div_start, div_done;
  logic [DIVIDEND_W-1:0] dividend;
  logic [DW-1:0]         quotient;
  logic [STEP_BITS-1:0]  divisor;
  logic [DW-1:0]         b_ch, a_ch;

  assign accept  = start && (state_q == ST_IDLE);
  assign cmd     = cmd_e'(cmd_i);
  assign full    = (count_q == CNT_W'(MAX_KEYS));
  // playback ends when the next segment would need a key not stored yet
  assign seg_end = {2'b00, seg_q} + (CNT_W+1)'(1) + {1'b0, MIN_KEYS};

  assign mem_wdata = {key_turn_i, key_z_i, key_x_i};

  // divider operands: exact 33-bit difference of this channel's two keys
  assign b_ch     = rdata_q[ch_q];
  assign a_ch     = akey_q[ch_q];
  assign dividend = {b_ch[DW-1], b_ch} - {a_ch[DW-1], a_ch};
  assign divisor  = (steps_q == '0) ? STEP_BITS'(1) : steps_q;

  klp_serial_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    cur_d      = cur_q;
    step_d     = step_q;
    akey_d     = akey_q;
    run_d      = run_q;
    seg_d      = seg_q;
    tick_d     = tick_q;
    steps_d    = steps_q;
    ch_d       = ch_q;
    load_cur_d = load_cur_q;
    done_d     = 1'b0;
    ended_d    = ended_q;
    rej_d      = rej_q;
    mem_we     = 1'b0;
    div_start  = 1'b0;
    rd_addr    = seg_q + KEY_AW'(1);

    if (cfg_valid_i) begin
      steps_d = cfg_data_i;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          ended_d = 1'b0;
          rej_d   = 1'b0;
          done_d  = 1'b1;
          case (cmd)
            CMD_STORE: begin
              if (full) begin
                rej_d = 1'b1;
              end else begin
                mem_we  = 1'b1;
                count_d = count_q + CNT_W'(1);
              end
            end
            CMD_PLAY: begin
              if (!run_q && (count_q >= MIN_KEYS)) begin
                seg_d      = '0;
                tick_d     = '0;
                load_cur_d = 1'b1;
                done_d     = 1'b0;
                state_d    = ST_RD_A;
              end else begin
                run_d = 1'b0;
                rej_d = 1'b1;
              end
            end
            CMD_TICK: begin
              if (run_q) begin
                if (tick_q >= steps_q) begin
                  if (seg_end > {1'b0, count_q}) begin
                    seg_d   = '0;
                    run_d   = 1'b0;
                    ended_d = 1'b1;
                  end else begin
                    seg_d      = seg_q + KEY_AW'(1);
                    tick_d     = '0;
                    load_cur_d = 1'b0;
                    done_d     = 1'b0;
                    state_d    = ST_RD_A;
                  end
                end else begin
                  for (int c = 0; c < NUM_CH; c++) begin
                    cur_d[c] = cur_q[c] + step_q[c];
                  end
                  tick_d = tick_q + STEP_BITS'(1);
                end
              end
            end
            default: begin
              // no-op: result shows current state
            end
          endcase
        end
      end
      ST_RD_A: begin
        rd_addr = seg_q;
        state_d = ST_RD_B;
      end
      ST_RD_B: begin
        // rdata holds key[seg]; key[seg+1] arrives next cycle and stays put
        akey_d = rdata_q;
        if (load_cur_q) begin
          cur_d = rdata_q;
        end
        ch_d    = '0;
        state_d = ST_DIV_GO;
      end
      ST_DIV_GO: begin
        div_start = 1'b1;
        state_d   = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_done) begin
          step_d[ch_q] = quotient;
          if (ch_q == CH_W'(NUM_CH - 1)) begin
            run_d   = 1'b1;
            done_d  = 1'b1;
            state_d = ST_IDLE;
          end else begin
            ch_d    = ch_q + CH_W'(1);
            state_d = ST_DIV_GO;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      count_q    <= '0;
      cur_q      <= '0;
      step_q     <= '0;
      run_q      <= 1'b0;
      seg_q      <= '0;
      tick_q     <= '0;
      steps_q    <= STEPS_RESET;
      ch_q       <= '0;
      load_cur_q <= 1'b0;
      done_q     <= 1'b0;
      ended_q    <= 1'b0;
      rej_q      <= 1'b0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      cur_q      <= cur_d;
      step_q     <= step_d;
      run_q      <= run_d;
      seg_q      <= seg_d;
      tick_q     <= tick_d;
      steps_q    <= steps_d;
      ch_q       <= ch_d;
      load_cur_q <= load_cur_d;
      done_q     <= done_d;
      ended_q    <= ended_d;
      rej_q      <= rej_d;
    end
  end

  always_ff @(posedge clk_i) begin
    akey_q <= akey_d;
  end

  // keyframe table: one write port at the fill count, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[count_q[KEY_AW-1:0]] <= mem_wdata;
    end
    rdata_q <= mem_q[rd_addr];
  end

  assign busy        = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign done_o      = done_q;
  assign pos_x_o     = cur_q[0];
  assign pos_z_o     = cur_q[1];
  assign heading_o   = cur_q[2];
  assign playing_o   = run_q;
  assign segment_o   = seg_q;
  assign ended_o     = ended_q;
  assign rejected_o  = rej_q;

endmodule

`default_nettype wire

@@ rtl/klp_serial_div.sv @@
// klp_serial_div: bit-serial restoring divider, signed dividend by unsigned divisor,
// quotient truncated toward zero. Depends on klp_pkg.
`default_nettype none

module klp_serial_div
  import klp_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic [DIVIDEND_W-1:0] dividend_i,
  input  wire logic [STEP_BITS-1:0]  divisor_i,
  output logic                       done_o,
  output logic [DW-1:0]              quotient_o
);

  logic [DIVIDEND_W-1:0] shreg_q, shreg_d;   // dividend bits out, quotient bits in
  logic [STEP_BITS-1:0]  rem_q, rem_d;
  logic [STEP_BITS-1:0]  dvsr_q, dvsr_d;
  logic [DIV_CW-1:0]     cnt_q, cnt_d;
  logic                  neg_q, neg_d;
  logic                  done_q, done_d;

  logic [STEP_BITS:0]    shifted;
  logic [STEP_BITS+1:0]  trial;
  logic [DIVIDEND_W-1:0] quot_full;

  always_comb begin
    shreg_d = shreg_q;
    rem_d   = rem_q;
    dvsr_d  = dvsr_q;
    cnt_d   = cnt_q;
    neg_d   = neg_q;
    done_d  = 1'b0;
    shifted = {rem_q, shreg_q[DIVIDEND_W-1]};
    trial   = {1'b0, shifted} - {2'b00, dvsr_q};
    if (start_i) begin
      neg_d   = dividend_i[DIVIDEND_W-1];
      shreg_d = dividend_i[DIVIDEND_W-1] ? (DIVIDEND_W'(0) - dividend_i) : dividend_i;
      rem_d   = '0;
      dvsr_d  = divisor_i;
      cnt_d   = DIV_CW'(DIVIDEND_W);
    end else if (cnt_q != '0) begin
      // one quotient bit per cycle
      if (!trial[STEP_BITS+1]) begin
        rem_d   = trial[STEP_BITS-1:0];
        shreg_d = {shreg_q[DIVIDEND_W-2:0], 1'b1};
      end else begin
        rem_d   = shifted[STEP_BITS-1:0];
        shreg_d = {shreg_q[DIVIDEND_W-2:0], 1'b0};
      end
      cnt_d  = cnt_q - DIV_CW'(1);
      done_d = (cnt_q == DIV_CW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shreg_q <= shreg_d;
    rem_q   <= rem_d;
    dvsr_q  <= dvsr_d;
    neg_q   <= neg_d;
  end

  assign quot_full  = neg_q ? (DIVIDEND_W'(0) - shreg_q) : shreg_q;
  assign quotient_o = quot_full[DW-1:0];
  assign done_o     = done_q;

endmodule

`default_nettype wire
